>>> rtl/tlpt_pkg.sv
// Shared types and constants for the two-level page table engine.
// Holds the channel beat structs, command and status codes, and the
// controller-to-datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package tlpt_pkg;

  // Geometry fixed by the 32-bit, 4 KiB page address split.
  localparam int IDX_W   = 10;
  localparam int FLAG_W  = 12;
  localparam int FRAME_W = 20;

  // Command codes.
  localparam logic [1:0] CMD_MAP_PAGE  = 2'd0;
  localparam logic [1:0] CMD_MAP_TABLE = 2'd1;
  localparam logic [1:0] CMD_TRANSLATE = 2'd2;
  localparam logic [1:0] CMD_NONE      = 2'd3;

  // Result status codes.
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_ABSENT  = 2'd1;
  localparam logic [1:0] STS_ALIGN   = 2'd2;
  localparam logic [1:0] STS_NOSLOT  = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [31:0]       virt_addr;
    logic [31:0]       phys_addr;
    logic [FLAG_W-1:0] entry_flags;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] result_addr;
    logic [1:0]  status;
  } out_beat_t;

  // How the datapath builds the pending result.
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_ABSENT,
    RES_ALIGN,
    RES_NOSLOT,
    RES_XLATE
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     dir_clr;
    logic     dir_we;
    logic     slot_take;
    logic     tab_we_one;
    logic     tab_rd;
    logic     sweep_we;
    logic     cnt_clear;
    logic     cnt_inc;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       cnt_last;
    logic [1:0] cmd;
    logic       misaligned;
    logic       dir_present;
    logic       slots_full;
    logic       out_free;
  } dp_sts_t;

endpackage

>>> rtl/tlpt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tlpt_ctrl.sv
// Controller state machine of the page table engine.
// Depends on tlpt_pkg; drives the datapath only through dp_cmd_t.
`timescale 1ns / 1ps

module tlpt_ctrl import tlpt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SWEEP  = 6'b001000,
    S_TREAD  = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.dir_clr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.cnt_clear = 1'b1;
        case (sts.cmd) inside
          CMD_TRANSLATE: begin
            if (!sts.dir_present) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ABSENT;
              state_nxt    = S_RESP;
            end else begin
              cmd.tab_rd = 1'b1;
              state_nxt  = S_TREAD;
            end
          end
          CMD_MAP_PAGE, CMD_MAP_TABLE: begin
            if (sts.misaligned) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ALIGN;
              state_nxt    = S_RESP;
            end else if (!sts.dir_present && sts.slots_full) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_NOSLOT;
              state_nxt    = S_RESP;
            end else begin
              cmd.dir_we    = 1'b1;
              cmd.slot_take = !sts.dir_present;
              // A fresh table is zeroed as it is written, so it takes the sweep too.
              if (sts.cmd == CMD_MAP_TABLE || !sts.dir_present) begin
                state_nxt = S_SWEEP;
              end else begin
                cmd.tab_we_one = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_sel    = RES_ZERO;
                state_nxt      = S_RESP;
              end
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ZERO;
            state_nxt    = S_RESP;
          end
        endcase
      end
      S_SWEEP: begin
        cmd.sweep_we = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.cnt_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_nxt    = S_RESP;
        end
      end
      S_TREAD: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_XLATE;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register still occupied");

  a_slot_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.slot_take |-> !sts.slots_full)
    else $error("table slot taken with none left");

  a_sweep_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) && sts.cnt_last |=> state_r == S_RESP)
    else $error("sweep end did not move to response");

endmodule

>>> rtl/tlpt_dpath.sv
// Datapath of the page table engine: item registers, directory and table
// memories, slot counter, sweep counter and output register.
// Depends on tlpt_pkg and tlpt_ram.
`timescale 1ns / 1ps

module tlpt_dpath import tlpt_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_beat_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  input  logic      out_stall,
  output logic      out_valid,
  output out_beat_t out_data
);

  localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int DIR_W     = SLOT_W + FLAG_W;
  localparam int DIR_DEPTH = 2 ** IDX_W;
  localparam int TAB_DEPTH = TABLE_SLOTS * (2 ** IDX_W);
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  in_beat_t          item_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  slots_used_r;
  logic [IDX_W-1:0]  idx_r;
  logic [31:0]       res_addr_r;
  logic [1:0]        res_status_r;
  logic              out_valid_r;
  out_beat_t         out_data_r;

  logic [IDX_W-1:0]  d_idx, t_idx;
  logic [DIR_W-1:0]  dir_rdata, dir_wdata;
  logic [IDX_W-1:0]  dir_waddr;
  logic              dir_present;
  logic [SLOT_W-1:0] slot_cur, tab_wslot;
  logic [31:0]       tab_rdata, tab_wdata, page_entry, sweep_entry;
  logic [FRAME_W-1:0] sweep_frame;
  logic [TAB_AW-1:0] tab_waddr, tab_raddr;
  logic              tab_we;

  assign d_idx = item_r.virt_addr[31:32-IDX_W];
  assign t_idx = item_r.virt_addr[31-IDX_W:FLAG_W];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.dir_we) begin
      slot_r <= slot_cur;
    end
  end

  // Directory: cleared by the pass after reset, read at accept.
  assign dir_present = dir_rdata[0];
  assign slot_cur    = dir_present ? dir_rdata[DIR_W-1:FLAG_W] : slots_used_r[SLOT_W-1:0];
  assign dir_waddr   = cmd.dir_clr ? idx_r : d_idx;
  assign dir_wdata   = cmd.dir_clr ? '0 : {slot_cur, item_r.entry_flags};

  tlpt_ram #(.WIDTH(DIR_W), .DEPTH(DIR_DEPTH)) u_dir_ram (
    .clk   (clk),
    .we    (cmd.dir_clr | cmd.dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (cmd.capture),
    .raddr (in_data.virt_addr[31:32-IDX_W]),
    .rdata (dir_rdata)
  );

  // Table pool: slot-major, one row of entries per slot.
  assign page_entry  = {item_r.phys_addr[31:FLAG_W], item_r.entry_flags};
  assign sweep_frame = item_r.phys_addr[31:FLAG_W] + FRAME_W'(idx_r);
  always_comb begin
    if (item_r.cmd == CMD_MAP_TABLE) begin
      sweep_entry = {sweep_frame, item_r.entry_flags};
    end else if (idx_r == t_idx) begin
      sweep_entry = page_entry;
    end else begin
      sweep_entry = '0;
    end
  end

  assign tab_we    = cmd.tab_we_one | cmd.sweep_we;
  assign tab_wslot = cmd.sweep_we ? slot_r : slot_cur;
  assign tab_waddr = cmd.sweep_we ? TAB_AW'({slot_r, idx_r}) : TAB_AW'({slot_cur, t_idx});
  assign tab_wdata = cmd.sweep_we ? sweep_entry : page_entry;
  assign tab_raddr = TAB_AW'({slot_cur, t_idx});

  tlpt_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (cmd.tab_rd),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  // Slot allocation count and the shared clear/sweep index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= '0;
      idx_r        <= '0;
    end else begin
      if (cmd.slot_take) begin
        slots_used_r <= slots_used_r + CNT_W'(1);
      end
      if (cmd.cnt_clear) begin
        idx_r <= '0;
      end else if (cmd.cnt_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // Pending result.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_ABSENT: begin
          res_addr_r   <= '0;
          res_status_r <= STS_ABSENT;
        end
        RES_ALIGN: begin
          res_addr_r   <= '0;
          res_status_r <= STS_ALIGN;
        end
        RES_NOSLOT: begin
          res_addr_r   <= '0;
          res_status_r <= STS_NOSLOT;
        end
        RES_XLATE: begin
          if (tab_rdata[0]) begin
            res_addr_r   <= {tab_rdata[31:FLAG_W], item_r.virt_addr[FLAG_W-1:0]};
            res_status_r <= STS_OK;
          end else begin
            res_addr_r   <= '0;
            res_status_r <= STS_ABSENT;
          end
        end
        default: begin
          res_addr_r   <= '0;
          res_status_r <= STS_OK;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= '{result_addr: res_addr_r, status: res_status_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.cnt_last    = (idx_r == '1);
  assign sts.cmd         = item_r.cmd;
  assign sts.misaligned  = (|item_r.virt_addr[FLAG_W-1:0]) | (|item_r.phys_addr[FLAG_W-1:0]);
  assign sts.dir_present = dir_present;
  assign sts.slots_full  = (slots_used_r == CNT_W'(TABLE_SLOTS));
  assign sts.out_free    = !out_valid_r || !out_stall;

  a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slots_used_r <= CNT_W'(TABLE_SLOTS))
    else $error("slot count beyond pool size");

  a_tab_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tab_we |-> int'(tab_wslot) < TABLE_SLOTS)
    else $error("table write to a slot outside the pool");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result beat changed or dropped");

endmodule

>>> rtl/two_level_page_table_engine.sv
// Top level of the two-level page table engine.
// Depends on tlpt_pkg, tlpt_ctrl, tlpt_dpath (and tlpt_ram below it).
`timescale 1ns / 1ps

//  channel  direction  handshake            beat
//  in       input      in_valid / in_stall  in_beat_t: cmd, virt_addr, phys_addr, entry_flags
//  out      output     out_valid/ out_stall out_beat_t: result_addr, status
//
//  After reset the block clears all 1024 page directory entries, one entry a
//  cycle; in_stall stays high during that pass.
//  A result enters the output register from the pending result register in
//  S_RESP, once the output register is free. The pending result is loaded in
//  S_DECIDE for failed maps, the unused command, map_page into a present table
//  and a translate with an absent directory entry; a translate that reaches
//  the table loads it in S_TREAD, after the registered directory read and the
//  registered table read. map_table, and map_page that needs a new table,
//  sweep all 1024 entries of the table row through the single table write port.
//  The next item is accepted in the cycle after a result enters the output
//  register; out_stall only holds the engine when a second result is ready.
module two_level_page_table_engine import tlpt_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  // The controller sequences each beat; the datapath owns every store and
  // reports back only the few conditions the sequencing depends on.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  tlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // Table slots are handed out in order and never returned; a directory
  // entry whose present bit is clear claims a fresh slot on its next map.
  tlpt_dpath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
